// ===== hdl/esc_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_dec_pkg
// Shared types and codes of the escape framed stream decoder.
// ----------------------------------------------------------------------------
package esc_dec_pkg;

  localparam logic [7:0] ESC_CODE     = 8'h1B;
  localparam logic [7:0] CMD_NAME     = 8'h4E;
  localparam logic [7:0] CMD_DATA     = 8'h46;
  localparam logic [7:0] CMD_END_FILE = 8'h45;
  localparam logic [7:0] CMD_END_BAT  = 8'h5A;
  localparam logic [7:0] CMD_BYTE     = 8'h42;

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_END_FILE = 3'd2,
    KIND_END_BAT  = 3'd3,
    KIND_UNKNOWN  = 3'd4,
    KIND_DISCARD  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       bad_digit;
  } result_t;

endpackage

// ===== hdl/escape_framed_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// escape_framed_stream_decoder_unit
// Decodes an esc framed serial byte stream into name, data and control results.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with in_byte, restart, final_byte.
//   output channel: out_valid / out_stall with out_byte, out_kind, bad_digit.
//   each input byte gives zero or one result transaction.
//   config channel: cfg_valid / cfg_ready with cfg_data, bit 0 is
//   decode_enable; cfg_ready is always high, write only while idle.
//   an accepted byte is registered in the input register, decoded, and its
//   result is registered in the result register.
//   throughput: one byte per cycle while the receiver does not stall, set by
//   the single decode pass between the input register and the result register.
//   when the receiver stalls, the result register holds, then the input
//   register fills and in_stall rises until the result is taken.
//   reset: decoder state cleared, both registers empty, decode_enable 0.
// ----------------------------------------------------------------------------
module escape_framed_stream_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       restart,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       bad_digit,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import esc_dec_pkg::*;

  logic    decode_enable;
  item_t   in_item;
  item_t   item;
  logic    full;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      decode_enable <= cfg_data;
    end
  end

  assign in_item = '{in_byte: in_byte, restart: restart, final_byte: final_byte};
  assign fire    = full && advance;

  esc_dec_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .consume  (fire),
    .full     (full),
    .item     (item)
  );

  esc_dec_core u_core (
    .clk           (clk),
    .rst           (rst),
    .decode_enable (decode_enable),
    .fire          (fire),
    .item          (item),
    .res_valid     (res_valid),
    .res           (res)
  );

  esc_dec_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .advance   (advance),
    .out_res   (out_res)
  );

  assign out_byte  = out_res.out_byte;
  assign out_kind  = out_res.kind;
  assign bad_digit = out_res.bad_digit;

  // stall only while a byte is waiting in the input register
  assert property (@(posedge clk) disable iff (rst) in_stall |-> full)
    else $error("in_stall without a held byte");

  // control results carry no byte and no digit flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_END_FILE || out_kind == KIND_END_BAT)
    |-> out_byte == 8'd0 && !bad_digit)
    else $error("end result with payload");

  // digit flag only on escaped byte kinds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_digit |-> out_kind == KIND_DATA || out_kind == KIND_DISCARD)
    else $error("bad_digit on wrong kind");

  // a consumed byte leaves the input register unless refilled
  assert property (@(posedge clk) disable iff (rst)
    fire && !(in_valid && !in_stall) |=> !full)
    else $error("input register not freed");

endmodule

// ===== hdl/esc_dec_in_reg.sv =====
// ----------------------------------------------------------------------------
// esc_dec_in_reg
// Input register: holds one accepted byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module esc_dec_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  esc_dec_pkg::item_t  in_item,
  input  logic                consume,
  output logic                full,
  output esc_dec_pkg::item_t  item
);
  import esc_dec_pkg::*;

  logic load;

  // free when empty or when the held byte leaves this cycle
  assign in_stall = full && !consume;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (consume) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/esc_dec_core.sv =====
// ----------------------------------------------------------------------------
// esc_dec_core
// Decoder state and the single pass update for one byte.
// ----------------------------------------------------------------------------
module esc_dec_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 decode_enable,
  input  logic                 fire,
  input  esc_dec_pkg::item_t   item,
  output logic                 res_valid,
  output esc_dec_pkg::result_t res
);
  import esc_dec_pkg::*;

  typedef enum logic [1:0] {
    SEC_NONE = 2'd0,
    SEC_NAME = 2'd1,
    SEC_DATA = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_HIGH   = 2'd2,
    PH_LOW    = 2'd3
  } phase_t;

  section_t   section, section_next;
  phase_t     phase, phase_next;
  logic [7:0] hex_value, hex_value_next;
  logic       digit_error, digit_error_next;
  logic       finished, finished_next;

  logic       nib_ok;
  logic [3:0] nib;

  // hex digit decode, uppercase only
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
      nib = 4'(item.in_byte - 8'h30);
    end else if (item.in_byte >= 8'h41 && item.in_byte <= 8'h46) begin
      nib = 4'(item.in_byte - 8'h37);
    end else begin
      nib_ok = 1'b0;
    end
  end

  always_comb begin
    // restart clears state before the byte is looked at
    section_next     = item.restart ? SEC_NONE  : section;
    phase_next       = item.restart ? PH_NORMAL : phase;
    hex_value_next   = item.restart ? 8'd0      : hex_value;
    digit_error_next = item.restart ? 1'b0      : digit_error;
    finished_next    = item.restart ? 1'b0      : finished;
    res_valid        = 1'b0;
    res.out_byte     = 8'd0;
    res.kind         = KIND_NAME;
    res.bad_digit    = 1'b0;

    if (decode_enable && !finished_next) begin
      unique case (phase_next)
        PH_ESC: begin
          phase_next = PH_NORMAL;
          priority case (item.in_byte)
            CMD_NAME: section_next = SEC_NAME;
            CMD_DATA: section_next = SEC_DATA;
            CMD_END_FILE: begin
              finished_next = 1'b1;
              res_valid     = 1'b1;
              res.kind      = KIND_END_FILE;
            end
            CMD_END_BAT: begin
              finished_next = 1'b1;
              res_valid     = 1'b1;
              res.kind      = KIND_END_BAT;
            end
            CMD_BYTE: begin
              hex_value_next   = 8'd0;
              digit_error_next = 1'b0;
              if (!item.final_byte) begin
                phase_next = PH_HIGH;
              end
            end
            default: begin
              res_valid    = 1'b1;
              res.out_byte = item.in_byte;
              res.kind     = KIND_UNKNOWN;
            end
          endcase
          // stream ended right after esc B: empty escaped byte
          if (item.in_byte == CMD_BYTE && item.final_byte) begin
            res_valid = 1'b1;
          end
        end
        PH_HIGH: begin
          if (nib_ok) begin
            hex_value_next = hex_value_next | {nib, 4'd0};
          end else begin
            digit_error_next = 1'b1;
          end
          if (item.final_byte) begin
            res_valid  = 1'b1;
            phase_next = PH_NORMAL;
          end else begin
            phase_next = PH_LOW;
          end
        end
        PH_LOW: begin
          if (nib_ok) begin
            hex_value_next = hex_value_next | {4'd0, nib};
          end else begin
            digit_error_next = 1'b1;
          end
          res_valid  = 1'b1;
          phase_next = PH_NORMAL;
        end
        PH_NORMAL: begin
          if (item.in_byte == ESC_CODE) begin
            phase_next = PH_ESC;
          end else if (section_next == SEC_DATA) begin
            res_valid    = 1'b1;
            res.out_byte = item.in_byte;
            res.kind     = KIND_DATA;
          end else if (section_next == SEC_NAME) begin
            res_valid    = 1'b1;
            res.out_byte = item.in_byte;
            res.kind     = KIND_NAME;
          end
        end
        default: phase_next = PH_NORMAL;
      endcase

      // escaped byte result, taken after the digit update
      if (res_valid && (phase == PH_HIGH || phase == PH_LOW ||
          (phase == PH_ESC && item.in_byte == CMD_BYTE)) && !item.restart) begin
        res.out_byte  = hex_value_next;
        res.kind      = (section_next == SEC_DATA) ? KIND_DATA : KIND_DISCARD;
        res.bad_digit = digit_error_next;
      end

      if (item.final_byte) begin
        section_next     = SEC_NONE;
        phase_next       = PH_NORMAL;
        hex_value_next   = 8'd0;
        digit_error_next = 1'b0;
        finished_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section     <= SEC_NONE;
      phase       <= PH_NORMAL;
      hex_value   <= 8'd0;
      digit_error <= 1'b0;
      finished    <= 1'b0;
    end else if (fire) begin
      section     <= section_next;
      phase       <= phase_next;
      hex_value   <= hex_value_next;
      digit_error <= digit_error_next;
      finished    <= finished_next;
    end
  end

endmodule

// ===== hdl/esc_dec_out_reg.sv =====
// ----------------------------------------------------------------------------
// esc_dec_out_reg
// Result register: holds one decoded transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module esc_dec_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 res_valid,
  input  esc_dec_pkg::result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 advance,
  output esc_dec_pkg::result_t out_res
);
  import esc_dec_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      out_res <= res;
    end
  end

endmodule
